FILE: rtl/core/ofr_pkg.sv
// Package with shared constants, types and helpers for the overlap frame reframer.
`timescale 1ns / 1ps

package ofr_pkg;

  // Ring geometry. The ring depth is a power of two so pointers wrap by truncation.
  localparam int MAX_FRAME = 64;
  localparam int RING_AW   = $clog2(MAX_FRAME);
  localparam int HELD_W    = RING_AW + 1;

  // Field and register widths.
  localparam int SAMPLE_W    = 32;
  localparam int LEN_W       = 7;
  localparam int HOP_W       = 10;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 10;

  // Register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_LENGTH = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_HOP          = 1'b1;

  // Register reset values.
  localparam logic [LEN_W-1:0] FRAME_LENGTH_RESET = 7'd64;
  localparam logic [HOP_W-1:0] HOP_RESET          = 10'd32;

  // One command from the front to the back: store a sample, optionally emit a frame.
  typedef struct packed {
    logic [SAMPLE_W-1:0] word;
    logic [RING_AW-1:0]  wr_addr;
    logic                emit;
    logic [RING_AW-1:0]  start;
    logic [LEN_W-1:0]    len;
  } cmd_t;

  // Command queue status seen by both sides.
  typedef struct packed {
    logic not_empty;
    logic full;
  } queue_status_t;

  // Back end sequencer states.
  typedef enum logic {
    BK_IDLE,
    BK_EMIT
  } back_state_t;

  // Back end status for monitoring.
  typedef struct packed {
    logic emitting;
    logic last_issue;
  } back_status_t;

  // Clamp the programmed frame length to 1..MAX_FRAME.
  function automatic logic [LEN_W-1:0] eff_length(input logic [LEN_W-1:0] fl);
    logic [LEN_W-1:0] n;
    n = fl;
    if (n == '0) n = LEN_W'(1);
    if (n > LEN_W'(MAX_FRAME)) n = LEN_W'(MAX_FRAME);
    return n;
  endfunction

endpackage

FILE: rtl/core/ofr_front.sv
// Front end: configuration registers, skip handling and ring bookkeeping.
`timescale 1ns / 1ps

module ofr_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [ofr_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [ofr_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic [ofr_pkg::SAMPLE_W-1:0]         sample_word,
  input  logic                                 sample_valid,
  output logic                                 sample_stall,
  input  ofr_pkg::queue_status_t               q_status,
  output logic                                 push,
  output ofr_pkg::cmd_t                        push_cmd
);

  logic [ofr_pkg::LEN_W-1:0]   frame_length;
  logic [ofr_pkg::HOP_W-1:0]   hop;
  logic [ofr_pkg::HELD_W-1:0]  held_count, held_count_next;
  logic [ofr_pkg::RING_AW-1:0] oldest_pointer, oldest_pointer_next;
  logic [ofr_pkg::HOP_W-1:0]   skip_count, skip_count_next;

  logic                        accept;
  logic [ofr_pkg::LEN_W-1:0]   len;
  logic [ofr_pkg::HOP_W-1:0]   adv;
  logic [ofr_pkg::HELD_W-1:0]  held_after;
  logic [ofr_pkg::RING_AW-1:0] oldest_after;
  logic [ofr_pkg::RING_AW-1:0] wr_addr;
  logic                        emit;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_length <= ofr_pkg::FRAME_LENGTH_RESET;
      hop          <= ofr_pkg::HOP_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        ofr_pkg::REG_FRAME_LENGTH: frame_length <= cfg_data[ofr_pkg::LEN_W-1:0];
        ofr_pkg::REG_HOP:          hop          <= cfg_data[ofr_pkg::HOP_W-1:0];
        default: ;
      endcase
    end
  end

  // A beat is taken whenever the queue has room.
  assign sample_stall = q_status.full;
  assign accept       = sample_valid && !q_status.full;

  assign len = ofr_pkg::eff_length(frame_length);
  assign adv = (hop == '0) ? ofr_pkg::HOP_W'(1) : hop;

  // Where the sample lands and how the ring looks right after storing it.
  always_comb begin
    if (held_count == ofr_pkg::HELD_W'(ofr_pkg::MAX_FRAME)) begin
      wr_addr      = oldest_pointer;
      oldest_after = oldest_pointer + ofr_pkg::RING_AW'(1);
      held_after   = held_count;
    end else begin
      wr_addr      = oldest_pointer + held_count[ofr_pkg::RING_AW-1:0];
      oldest_after = oldest_pointer;
      held_after   = held_count + ofr_pkg::HELD_W'(1);
    end
    emit = (ofr_pkg::LEN_W'(held_after) >= len);
  end

  // Per accepted beat: count down a skip, keep the sample, or on emit drop hop samples or arm a skip.
  always_comb begin
    held_count_next     = held_count;
    oldest_pointer_next = oldest_pointer;
    skip_count_next     = skip_count;
    if (accept) begin
      if (skip_count != '0) begin
        skip_count_next = skip_count - ofr_pkg::HOP_W'(1);
      end else if (!emit) begin
        held_count_next     = held_after;
        oldest_pointer_next = oldest_after;
      end else if (adv <= ofr_pkg::HOP_W'(held_after)) begin
        held_count_next     = ofr_pkg::HELD_W'(ofr_pkg::HOP_W'(held_after) - adv);
        oldest_pointer_next = oldest_after + adv[ofr_pkg::RING_AW-1:0];
      end else begin
        skip_count_next     = adv - ofr_pkg::HOP_W'(held_after);
        held_count_next     = '0;
        oldest_pointer_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count     <= '0;
      oldest_pointer <= '0;
      skip_count     <= '0;
    end else begin
      held_count     <= held_count_next;
      oldest_pointer <= oldest_pointer_next;
      skip_count     <= skip_count_next;
    end
  end

  // Skipped samples never reach the queue.
  assign push             = accept && (skip_count == '0);
  assign push_cmd.word    = sample_word;
  assign push_cmd.wr_addr = wr_addr;
  assign push_cmd.emit    = emit;
  assign push_cmd.start   = oldest_after;
  assign push_cmd.len     = len;

endmodule

FILE: rtl/core/ofr_cmd_queue.sv
// Two-entry command queue between the front and the back end.
`timescale 1ns / 1ps

module ofr_cmd_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  ofr_pkg::cmd_t          push_cmd,
  input  logic                   pop,
  output ofr_pkg::cmd_t          head,
  output ofr_pkg::queue_status_t q_status
);

  ofr_pkg::cmd_t entries [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          do_push;
  logic          do_pop;

  assign do_push = push && (count != 2'd2);
  assign do_pop  = pop && (count != 2'd0);

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      count <= count + (do_push ? 2'd1 : 2'd0) - (do_pop ? 2'd1 : 2'd0);
    end
  end

  assign head               = entries[rd_ptr];
  assign q_status.not_empty = (count != 2'd0);
  assign q_status.full      = (count == 2'd2);

endmodule

FILE: rtl/core/ofr_back.sv
// Back end: sample ring memory and the frame read-out sequencer.
`timescale 1ns / 1ps

module ofr_back (
  input  logic                         clk,
  input  logic                         rst,
  input  ofr_pkg::cmd_t                head,
  input  ofr_pkg::queue_status_t       q_status,
  output logic                         pop,
  output logic [ofr_pkg::SAMPLE_W-1:0] frame_sample,
  output logic                         frame_last,
  output logic                         frame_valid,
  input  logic                         frame_stall,
  output ofr_pkg::back_status_t        bk_status
);

  logic [ofr_pkg::SAMPLE_W-1:0] ring [ofr_pkg::MAX_FRAME];
  logic [ofr_pkg::SAMPLE_W-1:0] ring_q;

  ofr_pkg::back_state_t         state, state_next;
  logic [ofr_pkg::RING_AW-1:0]  rd_ptr;
  logic [ofr_pkg::LEN_W-1:0]    remaining;
  logic                         rd_en;
  logic                         last_issue;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ofr_pkg::BK_IDLE: begin
        if (pop && head.emit) state_next = ofr_pkg::BK_EMIT;
      end
      ofr_pkg::BK_EMIT: begin
        if (last_issue) state_next = ofr_pkg::BK_IDLE;
      end
      default: state_next = ofr_pkg::BK_IDLE;
    endcase
  end

  // Sequencer outputs. A read issues only when the output register is free or draining.
  always_comb begin
    pop        = 1'b0;
    rd_en      = 1'b0;
    unique case (state)
      ofr_pkg::BK_IDLE: pop   = q_status.not_empty;
      ofr_pkg::BK_EMIT: rd_en = !frame_valid || !frame_stall;
      default: ;
    endcase
    last_issue = rd_en && (remaining == ofr_pkg::LEN_W'(1));
  end

  // Ring memory: every command stores its sample, reads are registered.
  always_ff @(posedge clk) begin
    if (pop) begin
      ring[head.wr_addr] <= head.word;
    end
    if (rd_en) begin
      ring_q <= ring[rd_ptr];
    end
  end

  // Read pointer and beat count of the frame in flight.
  always_ff @(posedge clk) begin
    if (pop) begin
      rd_ptr    <= head.start;
      remaining <= head.len;
    end else if (rd_en) begin
      rd_ptr    <= rd_ptr + ofr_pkg::RING_AW'(1);
      remaining <= remaining - ofr_pkg::LEN_W'(1);
    end
  end

  // State and output register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ofr_pkg::BK_IDLE;
      frame_valid <= 1'b0;
      frame_last  <= 1'b0;
    end else begin
      state <= state_next;
      if (rd_en) begin
        frame_valid <= 1'b1;
        frame_last  <= last_issue;
      end else if (!frame_stall) begin
        frame_valid <= 1'b0;
      end
    end
  end

  assign frame_sample         = ring_q;
  assign bk_status.emitting   = (state == ofr_pkg::BK_EMIT);
  assign bk_status.last_issue = last_issue;

endmodule

FILE: rtl/core/overlap_frame_reframer_unit.sv
// Flow: a sample that completes a frame passes through the command queue, is popped into
// the ring while the sequencer is idle, and its frame is read through the registered ring
// output, one beat per cycle while the output is not stalled. The back end takes no new
// command while it reads a frame out of the single-port ring; the front takes a beat per
// cycle into a two-entry queue while it is not full. Reset (rst, synchronous) empties the
// ring bookkeeping and queue, sets frame_length to 64 and hop to 32; ring contents stay.
`timescale 1ns / 1ps

module overlap_frame_reframer_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [ofr_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [ofr_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic [ofr_pkg::SAMPLE_W-1:0]         sample_word,
  input  logic                                 sample_valid,
  output logic                                 sample_stall,
  output logic [ofr_pkg::SAMPLE_W-1:0]         frame_sample,
  output logic                                 frame_last,
  output logic                                 frame_valid,
  input  logic                                 frame_stall
);

  ofr_pkg::cmd_t          push_cmd;
  ofr_pkg::cmd_t          head;
  ofr_pkg::queue_status_t q_status;
  ofr_pkg::back_status_t  bk_status;
  logic                   push;
  logic                   pop;

  // Front end: accepts beats and decides what each one does.
  ofr_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_word  (sample_word),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .q_status     (q_status),
    .push         (push),
    .push_cmd     (push_cmd)
  );

  // Command queue decouples the two halves.
  ofr_cmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .q_status (q_status)
  );

  // Back end: stores samples and reads frames out.
  ofr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .q_status     (q_status),
    .pop          (pop),
    .frame_sample (frame_sample),
    .frame_last   (frame_last),
    .frame_valid  (frame_valid),
    .frame_stall  (frame_stall),
    .bk_status    (bk_status)
  );

  // The back end never takes a command from an empty queue.
  assert property (@(posedge clk) disable iff (rst) pop |-> q_status.not_empty)
    else $error("command popped from an empty queue");

  // A new frame beat only appears while the sequencer is emitting.
  assert property (@(posedge clk) disable iff (rst)
    $rose(frame_valid) |-> $past(bk_status.emitting))
    else $error("output beat without an active frame");

  // The final read of a frame shows up as a flagged last beat.
  assert property (@(posedge clk) disable iff (rst)
    bk_status.last_issue |=> (frame_valid && frame_last))
    else $error("final frame beat not flagged as last");

endmodule
